// File: rtl/core/rgbhsl_pkg.sv
`timescale 1ns / 1ps

package rgbhsl_pkg;

   // Channel and result widths
   localparam int CH_W  = 8;
   localparam int OUT_W = 16;

   // Intermediate widths of the color math
   localparam int SUM_W = CH_W + 1;   // max + min
   localparam int NUM_W = 11;         // hue sector numerator, at most 6 * delta

   // Reciprocal divider: quotient = floor(x / divisor), with
   // recip = floor((2^FRAC_SHIFT - 1) / divisor) and one correction step.
   localparam int X_W        = 28;
   localparam int RECIP_W    = 27;
   localparam int DIV_W      = 12;
   localparam int QUO_W      = 17;
   localparam int REM_W      = 13;
   localparam int FRAC_SHIFT = 28;
   localparam int unsigned RecipOne = (2 ** FRAC_SHIFT) - 1;

   // Reciprocal table depth, one entry per 8-bit index
   localparam int TAB_DEPTH = 2 ** CH_W;

   typedef struct packed {
      logic               valid;
      logic [X_W-1:0]     x;
      logic [RECIP_W-1:0] recip;
      logic [DIV_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             valid;
      logic [OUT_W-1:0] quot;
   } div_rsp_type;

endpackage

// File: rtl/core/rgbhsl_recip_div.sv
`timescale 1ns / 1ps

module rgbhsl_recip_div (
   input  logic                    clock,
   input  logic                    reset,
   input  rgbhsl_pkg::div_req_type req,
   output rgbhsl_pkg::div_rsp_type rsp
);
   import rgbhsl_pkg::*;

   localparam int PROD_W = X_W + RECIP_W;
   localparam int BACK_W = X_W + 1;

   // Stage 1: estimate quotient, low by at most one
   logic [PROD_W-1:0] prod_in;
   logic              v1_ff;
   logic [QUO_W-1:0]  q1_ff;
   logic [X_W-1:0]    x1_ff;
   logic [DIV_W-1:0]  d1_ff;

   assign prod_in = PROD_W'(req.x) * PROD_W'(req.recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req.valid;
      end
      q1_ff <= prod_in[FRAC_SHIFT+QUO_W-1:FRAC_SHIFT];
      x1_ff <= req.x;
      d1_ff <= req.divisor;
   end

   // Stage 2: remainder of the estimate, below twice the divisor
   logic [BACK_W-1:0] back_in;
   logic [BACK_W-1:0] diff_in;
   logic              v2_ff;
   logic [QUO_W-1:0]  q2_ff;
   logic [REM_W-1:0]  rem2_ff;
   logic [DIV_W-1:0]  d2_ff;

   assign back_in = BACK_W'(q1_ff) * BACK_W'(d1_ff);
   assign diff_in = {1'b0, x1_ff} - back_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      q2_ff   <= q1_ff;
      rem2_ff <= diff_in[REM_W-1:0];
      d2_ff   <= d1_ff;
   end

   // Stage 3: bump the estimate when the remainder reaches the divisor
   logic [QUO_W-1:0] quot_in;
   div_rsp_type      rsp_ff;

   assign quot_in = q2_ff + QUO_W'(rem2_ff >= REM_W'(d2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= v2_ff;
      end
      rsp_ff.quot <= quot_in[OUT_W-1:0];
   end

   assign rsp = rsp_ff;

endmodule

// File: rtl/core/rgb_to_hsl_converter_core.sv
`timescale 1ns / 1ps

// Channel    Handshake           Payload
// ---------  ------------------  ------------------------------------------
// request    start / busy        req_red, req_green, req_blue (8 b each)
// response   rsp_valid (strobe)  rsp_hue, rsp_saturation, rsp_lightness (16 b)
//
// One pixel transaction per cycle; from acceptance to the strobe it passes through
// two color-math stages, then three stages of the reciprocal divider
// (multiply, remainder multiply, correction).
// busy is held low; a transaction is taken in every cycle that start is high.
// Synchronous reset drops all in-flight transactions; nothing needs clearing.
// The receiver cannot stall: each result shows for exactly one cycle.

module rgb_to_hsl_converter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rgbhsl_pkg::CH_W-1:0]    req_red,
   input  logic [rgbhsl_pkg::CH_W-1:0]    req_green,
   input  logic [rgbhsl_pkg::CH_W-1:0]    req_blue,
   output logic                           rsp_valid,
   output logic [rgbhsl_pkg::OUT_W-1:0]   rsp_hue,
   output logic [rgbhsl_pkg::OUT_W-1:0]   rsp_saturation,
   output logic [rgbhsl_pkg::OUT_W-1:0]   rsp_lightness
);
   import rgbhsl_pkg::*;

   localparam int HALF_SUM = (2 ** CH_W) - 1;        // 255: lightness one half
   localparam int FULL_SUM = 2 * HALF_SUM;           // 510
   localparam int LIGHT_W  = SUM_W + CH_W;           // sum * 257

   // The pipeline never holds off a transaction
   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // ------------------------------------------------------------------
   // Stage 1: max, min, delta, saturation denominator, hue numerator
   // ------------------------------------------------------------------
   logic [CH_W-1:0]  hi_in, lo_in, d_in, den_in;
   logic [SUM_W-1:0] sum_in, inv_sum_in;
   logic [NUM_W-1:0] n_in, d_w, r_w, g_w, b_w;

   always_comb begin
      hi_in = req_red;
      if (req_green > hi_in) hi_in = req_green;
      if (req_blue > hi_in) hi_in = req_blue;
      lo_in = req_red;
      if (req_green < lo_in) lo_in = req_green;
      if (req_blue < lo_in) lo_in = req_blue;
   end

   assign d_in       = hi_in - lo_in;
   assign sum_in     = SUM_W'(hi_in) + SUM_W'(lo_in);
   assign inv_sum_in = SUM_W'(FULL_SUM) - sum_in;
   // Use max+min up to one half lightness, the complement above it
   assign den_in     = (sum_in <= SUM_W'(HALF_SUM)) ? sum_in[CH_W-1:0]
                                                     : inv_sum_in[CH_W-1:0];

   assign d_w = NUM_W'(d_in);
   assign r_w = NUM_W'(req_red);
   assign g_w = NUM_W'(req_green);
   assign b_w = NUM_W'(req_blue);

   // Sector numerator in [0, 6*delta]; red wins ties, then green
   always_comb begin
      if (req_red == hi_in) begin
         if (req_green >= req_blue) begin
            n_in = g_w - b_w;
         end else begin
            n_in = NUM_W'(6) * d_w - (b_w - g_w);
         end
      end else if (req_green == hi_in) begin
         n_in = NUM_W'(2) * d_w + b_w - r_w;
      end else begin
         n_in = NUM_W'(4) * d_w + r_w - g_w;
      end
   end

   logic             s1_valid_ff, s1_grey_ff;
   logic [CH_W-1:0]  s1_d_ff, s1_den_ff;
   logic [SUM_W-1:0] s1_sum_ff;
   logic [NUM_W-1:0] s1_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_grey_ff <= (hi_in == lo_in);
      s1_d_ff    <= d_in;
      s1_den_ff  <= den_in;
      s1_sum_ff  <= sum_in;
      s1_n_ff    <= n_in;
   end

   // ------------------------------------------------------------------
   // Reciprocal tables, indexed by delta (hue) and denominator (saturation)
   // ------------------------------------------------------------------
   logic [RECIP_W-1:0] hue_rtab [TAB_DEPTH];
   logic [RECIP_W-1:0] sat_rtab [TAB_DEPTH];

   for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_rtab
      localparam int unsigned HueDiv = (i == 0) ? 1 : 12 * i;
      localparam int unsigned SatDiv = (i == 0) ? 1 : 2 * i;
      assign hue_rtab[i] = RECIP_W'(RecipOne / HueDiv);
      assign sat_rtab[i] = RECIP_W'(RecipOne / SatDiv);
   end

   // ------------------------------------------------------------------
   // Stage 2: dividend and divisor of each rounded division, lightness
   //   hue = floor((2*N*65536 + 6d) / 12d)
   //   sat = floor((2*d*65535 + den) / 2den)
   //   lightness = round(sum * 65535 / 510) = (sum*257 + 1) >> 1
   // A grey pixel divides zero by one, so both quotients come out zero.
   // ------------------------------------------------------------------
   logic [X_W-1:0]     hue_x_in, sat_x_in, d_x;
   logic [DIV_W-1:0]   hue_div_in, sat_div_in;
   logic [LIGHT_W-1:0] light_in;
   div_req_type        hue_req_ff, sat_req_ff;
   logic [OUT_W-1:0]   light2_ff;

   assign d_x = X_W'(s1_d_ff);

   always_comb begin
      if (s1_grey_ff) begin
         hue_x_in   = '0;
         hue_div_in = DIV_W'(1);
         sat_x_in   = '0;
         sat_div_in = DIV_W'(1);
      end else begin
         hue_x_in   = (X_W'(s1_n_ff) << 17) + X_W'(6) * d_x;
         hue_div_in = DIV_W'(12) * DIV_W'(s1_d_ff);
         sat_x_in   = (d_x << 17) - (d_x << 1) + X_W'(s1_den_ff);
         sat_div_in = DIV_W'({s1_den_ff, 1'b0});
      end
   end

   assign light_in = (LIGHT_W'(s1_sum_ff) << CH_W) + LIGHT_W'(s1_sum_ff) + LIGHT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_req_ff.valid <= 1'b0;
         sat_req_ff.valid <= 1'b0;
      end else begin
         hue_req_ff.valid <= s1_valid_ff;
         sat_req_ff.valid <= s1_valid_ff;
      end
      hue_req_ff.x       <= hue_x_in;
      hue_req_ff.recip   <= hue_rtab[s1_d_ff];
      hue_req_ff.divisor <= hue_div_in;
      sat_req_ff.x       <= sat_x_in;
      sat_req_ff.recip   <= sat_rtab[s1_den_ff];
      sat_req_ff.divisor <= sat_div_in;
      light2_ff          <= light_in[LIGHT_W-1:1];
   end

   // ------------------------------------------------------------------
   // Stages 3..5: two divider lanes; delay lightness to match them
   // ------------------------------------------------------------------
   div_rsp_type hue_rsp, sat_rsp;

   rgbhsl_recip_div u_hue_div (
      .clock (clock),
      .reset (reset),
      .req   (hue_req_ff),
      .rsp   (hue_rsp)
   );

   rgbhsl_recip_div u_sat_div (
      .clock (clock),
      .reset (reset),
      .req   (sat_req_ff),
      .rsp   (sat_rsp)
   );

   logic [OUT_W-1:0] light3_ff, light4_ff, light5_ff;

   always_ff @(posedge clock) begin
      light3_ff <= light2_ff;
      light4_ff <= light3_ff;
      light5_ff <= light4_ff;
   end

   // Hue wraps a full turn to zero by keeping the low 16 bits
   assign rsp_valid      = hue_rsp.valid;
   assign rsp_hue        = hue_rsp.quot;
   assign rsp_saturation = sat_rsp.quot;
   assign rsp_lightness  = light5_ff;

`ifndef ASSERT_OFF
   // Both divider lanes must stay in step
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      hue_rsp.valid == sat_rsp.valid)
      else $error("hue and saturation lanes out of step");

   // Every accepted transaction yields exactly one strobe when it leaves the divider
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted transaction lost");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result strobe without a transaction");

   // A grey pixel must come out with zero hue and saturation
   a_grey_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_red == req_green && req_green == req_blue)
      |-> ##5 (rsp_hue == '0 && rsp_saturation == '0))
      else $error("grey pixel with nonzero hue or saturation");
`endif

endmodule
